// ===== design/kps_pkg.sv =====
// Shared constants, types and the key layout table of the keypad scanner.
package kps_pkg;

    localparam int ROWS       = 4;
    localparam int COLS       = 3;
    localparam int COUNT_BITS = 16;
    localparam int ROW_W      = $clog2(ROWS);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX     = '1;
    localparam logic [15:0]           DEBOUNCE_RST  = 16'd10;

    // Register indexes of the configuration port
    localparam logic REG_DEBOUNCE = 1'b0;

    // Command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Character layout "123" / "456" / "789" / "*0#"
    localparam int LAYOUT_ROWS = 4;
    localparam int LAYOUT_COLS = 3;
    localparam logic [6:0] KEY_CHARS [LAYOUT_ROWS*LAYOUT_COLS] = '{
        7'h31, 7'h32, 7'h33,
        7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39,
        7'h2A, 7'h30, 7'h23
    };

    // Per-lane control for one accepted transaction
    typedef struct packed {
        logic             tick;   // scan tick accepted
        logic             query;  // query aimed at this lane
        logic             held;   // column level seen for this lane
        logic [ROW_W-1:0] row;    // scan row on a tick, key row on a query
    } t_lane_ctl;

    function automatic logic [6:0] key_char_of(input logic [1:0] row, input logic [1:0] col);
        logic [3:0] idx;
        idx = 4'(row) * 4'd3 + 4'(col);
        if (int'(row) < LAYOUT_ROWS && int'(col) < LAYOUT_COLS) begin
            key_char_of = KEY_CHARS[idx];
        end else begin
            key_char_of = 7'd0;
        end
    endfunction

endpackage

// ===== design/kps_lane.sv =====
// One column lane: hold counters and reported flags for every row of a column.
module kps_lane (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  kps_pkg::t_lane_ctl               i_ctl,
    input  logic [kps_pkg::COUNT_BITS-1:0]   i_threshold,
    output logic                             o_pressed
);
    import kps_pkg::*;

    logic [COUNT_BITS-1:0] r_count [ROWS];
    logic [ROWS-1:0]       r_rep;
    logic [COUNT_BITS-1:0] count_sel;
    logic                  hit;

    assign count_sel = r_count[i_ctl.row];
    assign hit       = i_ctl.query && (count_sel >= i_threshold) && !r_rep[i_ctl.row];
    assign o_pressed = hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_count[r] <= '0;
            end
            r_rep <= '0;
        end else begin
            if (i_ctl.tick) begin
                if (i_ctl.held) begin
                    // saturate instead of wrapping
                    if (count_sel != COUNT_MAX) begin
                        r_count[i_ctl.row] <= count_sel + 1'b1;
                    end
                end else begin
                    r_count[i_ctl.row] <= '0;
                    r_rep[i_ctl.row]   <= 1'b0;
                end
            end
            if (hit) begin
                r_rep[i_ctl.row] <= 1'b1;
            end
        end
    end

endmodule

// ===== design/kps_merge.sv =====
// Merge stage: combine lane results, look up the key character, hold the output register.
module kps_merge (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  logic                     i_query,
    input  logic [kps_pkg::COLS-1:0] i_lane_pressed,
    input  logic [1:0]               i_key_row,
    input  logic [1:0]               i_key_col,
    input  logic [3:0]               i_row_drive,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic [3:0]               o_row_drive,
    output logic                     o_pressed,
    output logic [6:0]               o_key_char
);
    import kps_pkg::*;

    logic r_valid;
    logic [3:0] r_row_drive;
    logic r_pressed;
    logic [6:0] r_key_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_row_drive <= i_row_drive;
            r_pressed   <= |i_lane_pressed;
            r_key_char  <= i_query ? key_char_of(i_key_row, i_key_col) : 7'd0;
        end
    end

    assign o_out_valid = r_valid;
    assign o_row_drive = r_row_drive;
    assign o_pressed   = r_pressed;
    assign o_key_char  = r_key_char;

endmodule

// ===== design/matrix_keypad_scan_debounce_unit.sv =====
// Top level of the keypad scanner: handshake, scan row, lanes, merge stage, APB register.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------------
//  input    | i_in_valid / o_in_ready     | i_command, i_col_levels, i_key_row, i_key_col
//  output   | o_out_valid / i_out_ready   | o_row_drive, o_pressed, o_key_char
//  config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// In every transaction the column lanes update their counters at the accepting edge
// and the merge stage loads the result register at that same edge.
// One transaction per cycle is accepted as long as the result register is empty or
// being drained; a stalled output holds the result and blocks only the next input.
// Reset (synchronous, active low) clears all hold counters, reported flags, the scan
// row and the output valid; the debounce threshold returns to ten ticks.
module matrix_keypad_scan_debounce_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [2:0]  i_col_levels,
    input  logic [1:0]  i_key_row,
    input  logic [1:0]  i_key_col,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_row_drive,
    output logic        o_pressed,
    output logic [6:0]  o_key_char,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kps_pkg::*;

    logic [15:0]      r_debounce;
    logic [ROW_W-1:0] r_scan_row;
    logic [ROW_W-1:0] n_scan_row;
    logic             in_acc;
    logic             tick_acc;
    logic             query_acc;
    logic             key_in_range;
    logic [ROW_W-1:0] key_row_idx;
    logic [COLS-1:0]  lane_pressed;
    logic [3:0]       row_drive_next;
    logic             apb_write;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RST;
        end else if (apb_write && paddr[2] == REG_DEBOUNCE) begin
            r_debounce <= pwdata[15:0];
        end
    end

    // Word index is paddr[2]; anything past the debounce register reads as zero
    assign prdata = (paddr[2] == REG_DEBOUNCE) ? {16'd0, r_debounce} : 32'd0;

    // ---------------- input handshake ----------------
    // Accept whenever the result register is free or drains this cycle
    assign o_in_ready = !o_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign tick_acc   = in_acc && (i_command == CMD_TICK);

    // A query outside the matrix changes nothing and answers with no press and a zero character
    assign key_in_range = (int'(i_key_row) < ROWS) && (int'(i_key_col) < COLS);
    assign query_acc    = in_acc && (i_command == CMD_QUERY) && key_in_range;
    assign key_row_idx  = ROW_W'(i_key_row);

    // ---------------- scan row ----------------
    // Advance after each tick, wrapping after the last row
    always_comb begin
        n_scan_row = r_scan_row;
        if (tick_acc) begin
            n_scan_row = (r_scan_row == ROW_W'(ROWS - 1)) ? '0 : r_scan_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_row <= '0;
        end else begin
            r_scan_row <= n_scan_row;
        end
    end

    // One-hot drive of the row that is current after this transaction; rows
    // beyond the 4-bit field read as no drive
    assign row_drive_next = 4'(4'b0001 << n_scan_row);

    // ---------------- column lanes ----------------
    for (genvar c = 0; c < COLS; c++) begin : g_lane
        t_lane_ctl lane_ctl;
        logic      held;

        // Only the three sampled column lines can be seen held
        if (c < 3) begin : g_sampled
            assign held = i_col_levels[c];
        end else begin : g_unsampled
            assign held = 1'b0;
        end

        assign lane_ctl.tick  = tick_acc;
        assign lane_ctl.query = query_acc && (int'(i_key_col) == c);
        assign lane_ctl.held  = held;
        assign lane_ctl.row   = (i_command == CMD_TICK) ? r_scan_row : key_row_idx;

        kps_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (lane_ctl),
            .i_threshold (COUNT_BITS'(r_debounce)),
            .o_pressed   (lane_pressed[c])
        );
    end

    // ---------------- merge and output register ----------------
    kps_merge u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (in_acc),
        .i_query        (query_acc),
        .i_lane_pressed (lane_pressed),
        .i_key_row      (i_key_row),
        .i_key_col      (i_key_col),
        .i_row_drive    (row_drive_next),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_row_drive    (o_row_drive),
        .o_pressed      (o_pressed),
        .o_key_char     (o_key_char)
    );

    // ---------------- assertions ----------------
    // At most one lane can report a press per transaction
    a_one_lane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(lane_pressed))
        else $error("more than one lane reported a press");

    // A tick never reports a press or a character
    a_tick_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_acc |=> (o_pressed == 1'b0) && (o_key_char == 7'd0))
        else $error("tick result carries press or character");

    // The scan row stays inside the matrix
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_scan_row) < ROWS)
        else $error("scan row beyond last row");

    // A reported press always names a key of the layout
    a_press_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pressed) |-> (o_key_char != 7'd0))
        else $error("press reported without a key character");

    // Row drive is one-hot or empty
    a_drive_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(o_row_drive))
        else $error("row drive not one-hot");

endmodule
